// ===== sv/pdtb_pkg.sv =====
// ----------------------------------------------------------------------------
// pdtb_pkg
// Types, codes and constants of the pausable delta timer with beat tracking.
// ----------------------------------------------------------------------------
`default_nettype none

package pdtb_pkg;

  localparam int COUNT_WIDTH = 48;
  localparam int BPB_W       = 5;
  localparam int BEAT_W      = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX        = '1;
  localparam logic [COUNT_WIDTH-1:0] BEAT_LEN_RESET = COUNT_WIDTH'(4285714);
  localparam logic [BPB_W-1:0]       BPB_RESET      = BPB_W'(4);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_START = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEAT_LENGTH   = CFG_IDX_W'(0),
    REG_BEATS_PER_BAR = CFG_IDX_W'(1)
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    cnt_t       count_now;
  } in_item_t;

  typedef struct packed {
    cnt_t              game_time;
    cnt_t              delta_ticks;
    logic [BEAT_W-1:0] beat_index;
    logic              beat_advanced;
    logic              is_paused;
  } out_item_t;

  typedef struct packed {
    cnt_t              base_time;
    cnt_t              prev_time;
    cnt_t              cur_time;
    cnt_t              stop_time;
    cnt_t              paused_total;
    logic              paused_flag;
    cnt_t              last_delta;
    cnt_t              beat_phase;
    logic [BEAT_W-1:0] beat_count;
  } tmr_state_t;

  typedef struct packed {
    cnt_t             beat_length;
    logic [BPB_W-1:0] beats_per_bar;
  } tmr_cfg_t;

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? CNT_MAX : s[COUNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/pausable_delta_timer_beat.sv =====
// An accepted item sits in the input register; its result is then loaded
//   into the result register. Throughput: one item per cycle while out_stall
//   is low; the timer state is updated in the same cycle that the result
//   register is loaded, so commands chain back to back.
// Reset (rst_n low, synchronous): timer state cleared, registers to defaults,
//   both pipeline registers emptied.
// ----------------------------------------------------------------------------
// pausable_delta_timer_beat
// Pausable delta timer with beat phase tracking, one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module pausable_delta_timer_beat (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  pdtb_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  wire                              out_stall,
  output pdtb_pkg::out_item_t              out_item,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [pdtb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [pdtb_pkg::COUNT_WIDTH-1:0]  cfg_data
);
  import pdtb_pkg::*;

  in_item_t   in_item_r;
  logic       in_vld_r;
  out_item_t  out_item_r;
  logic       out_vld_r;
  tmr_state_t st_r;
  tmr_state_t st_nxt;
  tmr_cfg_t   cfg_r;
  out_item_t  res;
  logic       advance;
  logic       fire;

  assign advance   = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && advance;
  assign in_stall  = in_vld_r && !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  pdtb_core u_core (
    .item   (in_item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
      cfg_r.beat_length   <= BEAT_LEN_RESET;
      cfg_r.beats_per_bar <= BPB_RESET;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BEAT_LENGTH) begin
          cfg_r.beat_length <= cfg_data;
        end else if (cfg_index == REG_BEATS_PER_BAR) begin
          cfg_r.beats_per_bar <= cfg_data[BPB_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pdtb_core.sv =====
// ----------------------------------------------------------------------------
// pdtb_core
// Next-state and result logic for one command: timebase, pause bookkeeping,
// delta measurement and beat phase accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module pdtb_core (
  input  pdtb_pkg::in_item_t   item,
  input  pdtb_pkg::tmr_state_t st,
  input  pdtb_pkg::tmr_cfg_t   cfg,
  output pdtb_pkg::tmr_state_t st_nxt,
  output pdtb_pkg::out_item_t  res
);
  import pdtb_pkg::*;

  cnt_t              now;
  cnt_t              delta;
  cnt_t              phase_sum;
  logic [BPB_W-1:0]  nb;
  logic              crossed;
  logic              advanced;
  cnt_t              run_d;
  cnt_t              gt;

  assign now = item.count_now;

  // tick datapath, used only for a running tick
  always_comb begin
    delta     = (now >= st.prev_time) ? now - st.prev_time : '0;
    phase_sum = sat_add(st.beat_phase, delta);
    crossed   = phase_sum > cfg.beat_length;
    nb        = BPB_W'(st.beat_count) + BPB_W'(1);
  end

  always_comb begin
    st_nxt   = st;
    advanced = 1'b0;
    unique case (mode_t'(item.mode))
      MODE_TICK: begin
        if (st.paused_flag) begin
          st_nxt.last_delta = '0;
        end else begin
          st_nxt.cur_time   = now;
          st_nxt.prev_time  = now;
          st_nxt.last_delta = delta;
          st_nxt.beat_phase = phase_sum;
          if (crossed) begin
            st_nxt.beat_phase = phase_sum - cfg.beat_length;
            st_nxt.beat_count = (nb == cfg.beats_per_bar) ? '0 : nb[BEAT_W-1:0];
            advanced          = 1'b1;
          end
        end
      end
      MODE_RESET: begin
        st_nxt.base_time   = now;
        st_nxt.prev_time   = now;
        st_nxt.stop_time   = '0;
        st_nxt.paused_flag = 1'b0;
      end
      MODE_START: begin
        if (st.paused_flag) begin
          if (now > st.stop_time) begin
            st_nxt.paused_total = sat_add(st.paused_total, now - st.stop_time);
          end
          st_nxt.prev_time   = now;
          st_nxt.stop_time   = '0;
          st_nxt.paused_flag = 1'b0;
        end
      end
      MODE_STOP: begin
        if (!st.paused_flag) begin
          st_nxt.stop_time   = now;
          st_nxt.paused_flag = 1'b1;
        end
      end
      default: st_nxt = st;
    endcase
  end

  // game time from the updated state, clamped at zero
  always_comb begin
    run_d = st_nxt.cur_time - st_nxt.base_time;
    if (st_nxt.paused_flag) begin
      gt = (st_nxt.stop_time >= st_nxt.base_time) ?
           st_nxt.stop_time - st_nxt.base_time : '0;
    end else if (st_nxt.cur_time < st_nxt.base_time) begin
      gt = '0;
    end else begin
      gt = (run_d >= st_nxt.paused_total) ? run_d - st_nxt.paused_total : '0;
    end
  end

  assign res.game_time     = gt;
  assign res.delta_ticks   = st_nxt.last_delta;
  assign res.beat_index    = st_nxt.beat_count;
  assign res.beat_advanced = advanced;
  assign res.is_paused     = st_nxt.paused_flag;

endmodule

`default_nettype wire

// ===== sv/pdtb_checker.sv =====
// ----------------------------------------------------------------------------
// pdtb_checker
// Port-level checks of the timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdtb_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_stall,
  input pdtb_pkg::out_item_t out_item
);
  import pdtb_pkg::*;

  // stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item dropped or changed");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item.game_time))
    else $error("stalled game time changed");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a beat can only be crossed by a running tick
  a_beat_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.beat_advanced |-> !out_item.is_paused)
    else $error("beat advanced while paused");

endmodule

bind pausable_delta_timer_beat pdtb_checker u_pdtb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ===== test/tb_pausable_delta_timer_beat.sv =====
// ----------------------------------------------------------------------------
// tb_pausable_delta_timer_beat
// Self-checking bench for the pausable delta timer: a local timer predictor
// runs alongside the block, and every result is compared field by field with
// the oldest expected result. Directed commands cover counter extremes, pause
// and resume corners and paused-time saturation. Random phases follow, each
// with its own beat length and bar size, and both sides idle at random.
// ----------------------------------------------------------------------------
module tb_pausable_delta_timer_beat;
  timeunit 1ns;
  timeprecision 1ps;

  import pdtb_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 185;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 120;
  localparam int CALM_FROM    = 1000;
  localparam int CALM_TO      = 1250;
  localparam int IDLE_PCT     = 18;
  localparam int MAX_PRINTS   = 100;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  cnt_t                 cfg_data  = '0;

  pausable_delta_timer_beat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // predicted timer state and registers
  cnt_t              t_base, t_prev, t_cur, t_stop, t_paused_sum, t_delta, t_phase;
  cnt_t              t_beat_len;
  logic [BPB_W-1:0]  t_bpb;
  logic              t_paused;
  logic [BEAT_W-1:0] t_beat;

  in_item_t  cmds_pending [$];
  out_item_t results_due  [$];

  int   cmds_queued = 0;
  int   items_taken = 0;
  int   errors      = 0;
  int   cycles      = 0;
  int   beats_seen  = 0;
  int   reg_writes  = 0;
  int   mode_count [4] = '{0, 0, 0, 0};
  logic in_fire     = 1'b0;
  logic calm;
  cnt_t clock_now;

  assign calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  task automatic timer_clear();
    t_base       = '0;
    t_prev       = '0;
    t_cur        = '0;
    t_stop       = '0;
    t_paused_sum = '0;
    t_delta      = '0;
    t_phase      = '0;
    t_paused     = 1'b0;
    t_beat       = '0;
    t_beat_len   = BEAT_LEN_RESET;
    t_bpb        = BPB_RESET;
  endtask

  function automatic out_item_t timer_predict(input in_item_t it);
    cnt_t                 now;
    cnt_t                 span;
    logic [COUNT_WIDTH:0] sum;
    logic [BPB_W-1:0]     nb;
    out_item_t            res;
    now = it.count_now;
    res = '0;
    mode_count[it.mode]++;
    case (mode_t'(it.mode))
      MODE_TICK: begin
        if (t_paused) begin
          t_delta = '0;
        end else begin
          t_cur   = now;
          t_delta = (now >= t_prev) ? cnt_t'(now - t_prev) : '0;
          t_prev  = now;
          sum     = {1'b0, t_phase} + {1'b0, t_delta};
          t_phase = sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
          if (t_phase > t_beat_len) begin
            nb      = {1'b0, t_beat} + BPB_W'(1);
            t_phase = t_phase - t_beat_len;
            t_beat  = (nb == t_bpb) ? '0 : nb[BEAT_W-1:0];
            res.beat_advanced = 1'b1;
            beats_seen++;
          end
        end
      end
      MODE_RESET: begin
        t_base   = now;
        t_prev   = now;
        t_stop   = '0;
        t_paused = 1'b0;
      end
      MODE_START: begin
        if (t_paused) begin
          // a counter that went backwards adds no paused time
          if (now > t_stop) begin
            sum          = {1'b0, t_paused_sum} + {1'b0, cnt_t'(now - t_stop)};
            t_paused_sum = sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
          end
          t_prev   = now;
          t_stop   = '0;
          t_paused = 1'b0;
        end
      end
      default: begin
        if (!t_paused) begin
          t_stop   = now;
          t_paused = 1'b1;
        end
      end
    endcase
    if (t_paused) begin
      res.game_time = (t_stop >= t_base) ? cnt_t'(t_stop - t_base) : '0;
    end else if (t_cur < t_base) begin
      res.game_time = '0;
    end else begin
      span          = t_cur - t_base;
      res.game_time = (span >= t_paused_sum) ? cnt_t'(span - t_paused_sum) : '0;
    end
    res.delta_ticks = t_delta;
    res.beat_index  = t_beat;
    res.is_paused   = t_paused;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // input handshake, prediction and result checking
  always @(posedge clk) begin : monitor
    out_item_t due;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        results_due.push_back(timer_predict(in_item));
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due", 64'(out_item.game_time), '0);
        end else begin
          due = results_due.pop_front();
          if (out_item.game_time !== due.game_time)
            report_mismatch("game_time", 64'(out_item.game_time),
                            64'(due.game_time));
          if (out_item.delta_ticks !== due.delta_ticks)
            report_mismatch("delta_ticks", 64'(out_item.delta_ticks),
                            64'(due.delta_ticks));
          if (out_item.beat_index !== due.beat_index)
            report_mismatch("beat_index", 64'(out_item.beat_index),
                            64'(due.beat_index));
          if (out_item.beat_advanced !== due.beat_advanced)
            report_mismatch("beat_advanced", 64'(out_item.beat_advanced),
                            64'(due.beat_advanced));
          if (out_item.is_paused !== due.is_paused)
            report_mismatch("is_paused", 64'(out_item.is_paused),
                            64'(due.is_paused));
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (cmds_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_item  <= cmds_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side stall, with one long hold-off so the block backs up
  always @(negedge clk) begin : stall_gen
    int   hold_left;
    logic hold_done;
    logic stall_next;
    if (hold_done !== 1'b1 && items_taken >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else if (calm) begin
      stall_next = 1'b0;
    end else begin
      stall_next = ($urandom_range(99) < IDLE_PCT);
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               results_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_cmd(input mode_t m, input cnt_t count);
    in_item_t it;
    it.mode      = m;
    it.count_now = count;
    cmds_pending.push_back(it);
    cmds_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cnt_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BEAT_LENGTH)
      t_beat_len = data;
    else if (idx == REG_BEATS_PER_BAR)
      t_bpb = data[BPB_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (items_taken != cmds_queued || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // counter advance scaled to the beat length so beats cross often
  function automatic cnt_t step_size();
    logic [63:0] cap;
    logic [63:0] r;
    if (t_beat_len == '0)
      cap = 64'd16;
    else if (t_beat_len > cnt_t'(64'h7fff_ffff))
      cap = 64'hffff_ffff;
    else
      cap = {16'd0, t_beat_len} * 64'd2;
    r = {$urandom, $urandom};
    return cnt_t'(r % (cap + 64'd1));
  endfunction

  task automatic queue_random(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        clock_now += step_size();
        queue_cmd(MODE_TICK, clock_now);
      end else if (pick < 77) begin
        clock_now += step_size();
        queue_cmd(MODE_STOP, clock_now);
      end else if (pick < 86) begin
        clock_now += step_size();
        queue_cmd(MODE_START, clock_now);
      end else if (pick < 90) begin
        queue_cmd(MODE_RESET, clock_now);
      end else if (pick < 96) begin
        clock_now = cnt_t'({$urandom, $urandom});
        queue_cmd(mode_t'($urandom_range(3)), clock_now);
      end else begin
        clock_now -= cnt_t'($urandom_range(1000));
        queue_cmd(MODE_TICK, clock_now);
      end
    end
  endtask

  initial begin : stimulus
    cnt_t             len_set [NUM_PHASES];
    logic [BPB_W-1:0] bpb_set [NUM_PHASES];
    cnt_t             d;
    len_set = '{cnt_t'(1), cnt_t'(0), cnt_t'(50), CNT_MAX,
                cnt_t'({$urandom, $urandom}), cnt_t'(7), cnt_t'(200), BEAT_LEN_RESET};
    bpb_set = '{5'd1, 5'd4, 5'd16, 5'd31, BPB_W'($urandom_range(31)), 5'd0, 5'd3, 5'd5};
    timer_clear();
    clock_now = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners with the reset register values
    queue_cmd(MODE_TICK,  '0);
    queue_cmd(MODE_TICK,  cnt_t'(1000));
    queue_cmd(MODE_TICK,  CNT_MAX);                // huge delta, phase reaches the maximum
    queue_cmd(MODE_TICK,  cnt_t'(5));              // counter went backwards
    queue_cmd(MODE_STOP,  cnt_t'(100));
    queue_cmd(MODE_STOP,  cnt_t'(200));            // already paused
    queue_cmd(MODE_TICK,  cnt_t'(300));            // tick while paused
    queue_cmd(MODE_START, cnt_t'(50));             // resume behind stop time
    queue_cmd(MODE_START, cnt_t'(60));             // already running
    queue_cmd(MODE_RESET, cnt_t'(1000));
    queue_cmd(MODE_TICK,  cnt_t'(500));            // current below base
    queue_cmd(MODE_STOP,  '0);                     // stop below base
    queue_cmd(MODE_START, CNT_MAX);
    queue_cmd(MODE_STOP,  '0);
    queue_cmd(MODE_START, CNT_MAX);                // paused total saturates
    queue_cmd(MODE_TICK,  CNT_MAX);
    queue_cmd(MODE_RESET, '0);
    queue_cmd(MODE_RESET, CNT_MAX);
    queue_cmd(MODE_TICK,  cnt_t'(48'h5555_5555_5555));
    queue_cmd(MODE_TICK,  cnt_t'(48'haaaa_aaaa_aaaa));
    queue_cmd(MODE_STOP,  CNT_MAX);
    queue_cmd(MODE_TICK,  '0);
    queue_cmd(MODE_START, '0);
    queue_cmd(MODE_RESET, '0);
    clock_now = '0;
    queue_random(PHASE_ITEMS);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_BEAT_LENGTH, len_set[p]);
      d = cnt_t'({$urandom, $urandom});            // upper bits must be dropped
      d[BPB_W-1:0] = bpb_set[p];
      write_reg(REG_BEATS_PER_BAR, d);
      write_reg(REG_SPARE_A, cnt_t'({$urandom, $urandom}));
      write_reg(REG_SPARE_B, cnt_t'({$urandom, $urandom}));
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    if (results_due.size() != 0)
      report_mismatch("results never delivered", 64'(results_due.size()), '0);
    $display("Ran %0d commands: %0d ticks, %0d resets, %0d starts, %0d stops.",
             items_taken, mode_count[MODE_TICK], mode_count[MODE_RESET],
             mode_count[MODE_START], mode_count[MODE_STOP]);
    $display("Saw %0d beat crossings over %0d register writes, %0d mismatches.",
             beats_seen, reg_writes, errors);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== pausable_delta_timer_beat.f =====
sv/pdtb_pkg.sv
sv/pdtb_core.sv
sv/pausable_delta_timer_beat.sv
sv/pdtb_checker.sv
test/tb_pausable_delta_timer_beat.sv
